>>> hw/rtl/rms_pkg.sv
// rms_pkg: shared types, codes and constants of the robot mode supervisor.
// No dependencies; every other file of the block imports it.

package rms_pkg;

    localparam int VEL_BITS   = 16;
    localparam int VALUE_BITS = 16;
    localparam int TICK_BITS  = 16;
    localparam int PROF_BITS  = 4;
    localparam int CFG_IDX_BITS = 2;

    localparam logic [15:0] TIMEOUT_RESET = 16'd10;   // 10 ticks of 100 ms is 1.0 s

    // Non-latching error codes: they clear the error latch
    localparam logic [VALUE_BITS-1:0] ERR_CLEAR_A = 16'd210;
    localparam logic [VALUE_BITS-1:0] ERR_CLEAR_B = 16'd211;
    localparam logic [VALUE_BITS-1:0] XS_MAX_CODE = 16'd4;

    typedef enum logic [3:0] {
        KIND_MAN_DRIVE  = 4'd0,
        KIND_AUTO_DRIVE = 4'd1,
        KIND_MAN_XFORM  = 4'd2,
        KIND_AUTO_XFORM = 4'd3,
        KIND_MODE       = 4'd4,
        KIND_ESTOP      = 4'd5,
        KIND_GO         = 4'd6,
        KIND_STATUS     = 4'd7,
        KIND_ERROR      = 4'd8,
        KIND_TICK       = 4'd9
    } kind_t;

    typedef enum logic [2:0] {
        ACT_IDLE    = 3'd0,
        ACT_DRIVE   = 3'd1,
        ACT_XFORM   = 3'd2,
        ACT_XPAUSED = 3'd3,
        ACT_ESTOP   = 3'd4,
        ACT_ERROR   = 3'd5
    } action_t;

    localparam logic [2:0] XS_IDLE    = 3'd0;
    localparam logic [2:0] XS_RUNNING = 3'd1;
    localparam logic [2:0] XS_PAUSED  = 3'd2;
    localparam logic [2:0] XS_DONE    = 3'd3;
    localparam logic [2:0] XS_FAILED  = 3'd4;
    localparam logic [2:0] XS_UNKNOWN = 3'd7;

    localparam logic [2:0] FB_NONE    = 3'd0;
    localparam logic [2:0] FB_ACCEPT  = 3'd1;
    localparam logic [2:0] FB_BUSY    = 3'd2;
    localparam logic [2:0] FB_ESTOP   = 3'd3;
    localparam logic [2:0] FB_ERROR   = 3'd4;
    localparam logic [2:0] FB_SOURCE  = 3'd5;
    localparam logic [2:0] FB_TIMEOUT = 3'd6;
    localparam logic [2:0] FB_CLEARED = 3'd7;

    localparam logic [1:0] PR_NONE   = 2'd0;
    localparam logic [1:0] PR_PAUSE  = 2'd1;
    localparam logic [1:0] PR_RESUME = 2'd2;

    localparam logic [CFG_IDX_BITS-1:0] CFG_TIMEOUT       = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_DEFAULT_PROF  = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_XFORM_PROF    = 2'd2;

    typedef struct packed {
        logic [3:0]                   kind;
        logic [VALUE_BITS-1:0]        value;
        logic signed [VEL_BITS-1:0]   linear_vel;
        logic signed [VEL_BITS-1:0]   angular_vel;
    } rms_item_t;

    typedef struct packed {
        logic [TICK_BITS-1:0] timeout_ticks;
        logic [PROF_BITS-1:0] default_profile;
        logic [PROF_BITS-1:0] transform_profile;
    } rms_cfg_t;

    typedef struct packed {
        logic                 ctrl_mode;
        action_t              act_state;
        logic [2:0]           xform_status;
        logic                 estop_latch;
        logic                 error_latch;
        logic [TICK_BITS-1:0] ticks_since_auto;
    } rms_state_t;

    typedef struct packed {
        logic                        drive_valid;
        logic signed [VEL_BITS-1:0]  drive_linear;
        logic signed [VEL_BITS-1:0]  drive_angular;
        logic                        request_valid;
        logic [VALUE_BITS-1:0]       request_code;
        logic [1:0]                  pause_resume;
        logic                        profile_valid;
        logic [PROF_BITS-1:0]        profile_id;
        logic [2:0]                  feedback_code;
        logic                        mode_now;
        logic [2:0]                  action_now;
    } rms_result_t;

endpackage

>>> hw/rtl/rms_if.sv
// rms_if: valid/ready channel interfaces of the robot mode supervisor.
// Depends on rms_pkg for field widths.

interface rms_evt_if
    import rms_pkg::*;
();
    logic                       valid;
    logic                       ready;
    logic [3:0]                 kind;
    logic [VALUE_BITS-1:0]      value;
    logic signed [VEL_BITS-1:0] linear_vel;
    logic signed [VEL_BITS-1:0] angular_vel;

    modport source (output valid, kind, value, linear_vel, angular_vel, input ready);
    modport sink   (input valid, kind, value, linear_vel, angular_vel, output ready);
endinterface

interface rms_res_if
    import rms_pkg::*;
();
    logic                       valid;
    logic                       ready;
    logic                       drive_valid;
    logic signed [VEL_BITS-1:0] drive_linear;
    logic signed [VEL_BITS-1:0] drive_angular;
    logic                       request_valid;
    logic [VALUE_BITS-1:0]      request_code;
    logic [1:0]                 pause_resume;
    logic                       profile_valid;
    logic [PROF_BITS-1:0]       profile_id;
    logic [2:0]                 feedback_code;
    logic                       mode_now;
    logic [2:0]                 action_now;

    modport source (output valid, drive_valid, drive_linear, drive_angular, request_valid,
                    request_code, pause_resume, profile_valid, profile_id,
                    feedback_code, mode_now, action_now, input ready);
    modport sink   (input valid, drive_valid, drive_linear, drive_angular, request_valid,
                    request_code, pause_resume, profile_valid, profile_id,
                    feedback_code, mode_now, action_now, output ready);
endinterface

interface rms_cfg_if
    import rms_pkg::*;
();
    logic                    valid;
    logic                    ready;
    logic [CFG_IDX_BITS-1:0] index;
    logic [15:0]             data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

>>> hw/rtl/robot_mode_supervisor_unit.sv
// robot_mode_supervisor_unit: top level of the robot mode supervisor.
// Depends on rms_pkg, the channel interfaces in rms_if.sv and rms_decide.
//
//  channel | dir | modport | payload
//  evt     | in  | sink    | kind, value, linear_vel, angular_vel
//  res     | out | source  | drive_*, request_*, pause_resume, profile_*, feedback_code,
//          |     |         | mode_now, action_now
//  cfg     | in  | sink    | index, data (always ready)
//
// One item per cycle sustained while res is ready: an event is taken into the input register,
// decided in one pass of rms_decide once the output register is free, and its result is
// then registered in the output register, from which it is offered on res.
// Supervisor state updates as the item moves into the output register.
// A stalled output holds its result; the input register takes one more item, then the
// event channel stalls until the result is taken.
// Reset clears state, valid flags and configuration (timeout 10 ticks, profiles 0).

module robot_mode_supervisor_unit
    import rms_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    rms_evt_if.sink     evt,
    rms_res_if.source   res,
    rms_cfg_if.sink     cfg
);

    logic        in_valid_reg;
    rms_item_t   item_reg;
    logic        out_valid_reg;
    rms_result_t result_reg;
    rms_state_t  state_reg;
    rms_state_t  state_next;
    rms_cfg_t    cfg_reg;
    rms_result_t result_next;
    logic        advance;
    logic        take;

    assign advance   = in_valid_reg && (!out_valid_reg || res.ready);
    assign evt.ready = !in_valid_reg || advance;
    assign take      = evt.valid && evt.ready;
    assign cfg.ready = 1'b1;

    rms_decide u_decide (
        .item       (item_reg),
        .state      (state_reg),
        .cfg        (cfg_reg),
        .state_next (state_next),
        .result     (result_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= '{ctrl_mode: 1'b0, act_state: ACT_IDLE,
                               xform_status: XS_IDLE, estop_latch: 1'b0,
                               error_latch: 1'b0, ticks_since_auto: '0};
        end
        else
        begin
            if (take)
                in_valid_reg <= 1'b1;
            else if (advance)
                in_valid_reg <= 1'b0;

            if (advance)
            begin
                out_valid_reg <= 1'b1;
                state_reg     <= state_next;
            end
            else if (res.ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            item_reg.kind        <= evt.kind;
            item_reg.value       <= evt.value;
            item_reg.linear_vel  <= evt.linear_vel;
            item_reg.angular_vel <= evt.angular_vel;
        end
        if (advance)
            result_reg <= result_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.timeout_ticks     <= TIMEOUT_RESET;
            cfg_reg.default_profile   <= '0;
            cfg_reg.transform_profile <= '0;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                CFG_TIMEOUT:      cfg_reg.timeout_ticks     <= cfg.data;
                CFG_DEFAULT_PROF: cfg_reg.default_profile   <= cfg.data[PROF_BITS-1:0];
                CFG_XFORM_PROF:   cfg_reg.transform_profile <= cfg.data[PROF_BITS-1:0];
                default: ;
            endcase
        end
    end

    assign res.valid         = out_valid_reg;
    assign res.drive_valid   = result_reg.drive_valid;
    assign res.drive_linear  = result_reg.drive_linear;
    assign res.drive_angular = result_reg.drive_angular;
    assign res.request_valid = result_reg.request_valid;
    assign res.request_code  = result_reg.request_code;
    assign res.pause_resume  = result_reg.pause_resume;
    assign res.profile_valid = result_reg.profile_valid;
    assign res.profile_id    = result_reg.profile_id;
    assign res.feedback_code = result_reg.feedback_code;
    assign res.mode_now      = result_reg.mode_now;
    assign res.action_now    = result_reg.action_now;

endmodule

>>> hw/rtl/rms_decide.sv
// rms_decide: one-item decision logic, next supervisor state and result.
// Depends on rms_pkg.

module rms_decide
    import rms_pkg::*;
(
    input  rms_item_t   item,
    input  rms_state_t  state,
    input  rms_cfg_t    cfg,
    output rms_state_t  state_next,
    output rms_result_t result
);

    logic                 busy;
    logic                 blocked;
    logic [2:0]           xs_new;
    logic [TICK_BITS-1:0] ticks_inc;

    assign busy = (state.xform_status == XS_RUNNING) || (state.xform_status == XS_PAUSED) ||
                  (state.act_state == ACT_XFORM) || (state.act_state == ACT_XPAUSED);
    assign blocked = state.estop_latch || state.error_latch;
    assign xs_new = (item.value <= XS_MAX_CODE) ? item.value[2:0] : XS_UNKNOWN;
    assign ticks_inc = (state.ticks_since_auto != '1) ? state.ticks_since_auto + 1'b1
                                                      : state.ticks_since_auto;

    always_comb
    begin
        state_next = state;
        result     = '0;
        case (item.kind)
            KIND_MAN_DRIVE, KIND_AUTO_DRIVE:
            begin
                // auto drive restarts the timeout even when rejected
                if (item.kind[0])
                    state_next.ticks_since_auto = '0;
                if (state.ctrl_mode != item.kind[0])
                    result.feedback_code = FB_SOURCE;
                else if (state.estop_latch)
                    result.feedback_code = FB_ESTOP;
                else if (state.error_latch)
                    result.feedback_code = FB_ERROR;
                else if (busy)
                    result.feedback_code = FB_BUSY;
                else
                begin
                    result.feedback_code = FB_ACCEPT;
                    result.drive_valid   = 1'b1;
                    result.drive_linear  = item.linear_vel;
                    result.drive_angular = item.angular_vel;
                    state_next.act_state = ACT_DRIVE;
                end
            end
            KIND_MAN_XFORM, KIND_AUTO_XFORM:
            begin
                if (state.ctrl_mode == item.kind[0] && !blocked)
                begin
                    result.profile_valid = 1'b1;
                    result.profile_id    = cfg.transform_profile;
                    result.drive_valid   = 1'b1;
                    result.request_valid = 1'b1;
                    result.request_code  = item.value;
                    state_next.act_state = ACT_XFORM;
                end
            end
            KIND_MODE:
            begin
                if (item.value[VALUE_BITS-1:1] == '0)
                begin
                    result.feedback_code = FB_CLEARED;
                    result.drive_valid   = 1'b1;
                    state_next.ctrl_mode = item.value[0];
                    if (!busy && !blocked)
                        state_next.act_state = ACT_IDLE;
                end
            end
            KIND_ESTOP:
            begin
                if (item.value != '0)
                begin
                    state_next.estop_latch = 1'b1;
                    result.drive_valid = 1'b1;
                    if (state.xform_status == XS_RUNNING)
                    begin
                        result.pause_resume = PR_PAUSE;
                        state_next.act_state = ACT_XPAUSED;
                    end
                    else
                        state_next.act_state = ACT_ESTOP;
                end
            end
            KIND_GO:
            begin
                if (item.value != '0)
                begin
                    state_next.estop_latch  = 1'b0;
                    state_next.error_latch  = 1'b0;
                    state_next.ctrl_mode    = 1'b0;
                    result.drive_valid   = 1'b1;
                    result.feedback_code = FB_CLEARED;
                    if (state.xform_status == XS_PAUSED)
                    begin
                        result.pause_resume = PR_RESUME;
                        state_next.act_state = ACT_XFORM;
                    end
                    else
                        state_next.act_state = ACT_IDLE;
                end
            end
            KIND_STATUS:
            begin
                state_next.xform_status = xs_new;
                case (xs_new)
                    XS_RUNNING: state_next.act_state = ACT_XFORM;
                    XS_PAUSED:  state_next.act_state = ACT_XPAUSED;
                    XS_DONE:
                    begin
                        result.profile_valid = 1'b1;
                        result.profile_id    = cfg.default_profile;
                        if (!blocked)
                            state_next.act_state = ACT_IDLE;
                    end
                    XS_FAILED:
                    begin
                        result.profile_valid = 1'b1;
                        result.profile_id    = cfg.default_profile;
                    end
                    default: ;
                endcase
            end
            KIND_ERROR:
            begin
                result.drive_valid = 1'b1;
                if (item.value == ERR_CLEAR_A || item.value == ERR_CLEAR_B)
                begin
                    state_next.error_latch = 1'b0;
                    result.profile_valid = 1'b1;
                    result.profile_id    = cfg.default_profile;
                    if (!state.estop_latch)
                        state_next.act_state = ACT_IDLE;
                end
                else
                begin
                    state_next.error_latch = 1'b1;
                    state_next.act_state   = ACT_ERROR;
                end
            end
            KIND_TICK:
            begin
                state_next.ticks_since_auto = ticks_inc;
                if (state.ctrl_mode && state.act_state == ACT_DRIVE &&
                    ticks_inc > cfg.timeout_ticks)
                begin
                    result.drive_valid   = 1'b1;
                    result.feedback_code = FB_TIMEOUT;
                    state_next.act_state = ACT_IDLE;
                end
            end
            default: ;
        endcase
        result.mode_now   = state_next.ctrl_mode;
        result.action_now = state_next.act_state;
    end

endmodule

>>> hw/rtl/rms_checker.sv
// rms_checker: port-level assertions for robot_mode_supervisor_unit, plus its bind.
// Depends on rms_pkg and on the top level's channel ports.

module rms_checker
    import rms_pkg::*;
(
    input logic                       clk,
    input logic                       rst_n,
    input logic                       res_valid,
    input logic                       res_ready,
    input logic                       drive_valid,
    input logic signed [VEL_BITS-1:0] drive_linear,
    input logic signed [VEL_BITS-1:0] drive_angular,
    input logic                       request_valid,
    input logic [VALUE_BITS-1:0]      request_code,
    input logic [1:0]                 pause_resume,
    input logic                       profile_valid,
    input logic [PROF_BITS-1:0]       profile_id,
    input logic [2:0]                 feedback_code,
    input logic [2:0]                 action_now
);

    // stalled result holds
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(drive_linear) &&
        $stable(feedback_code) && $stable(action_now) && $stable(request_code))
        else $error("result changed while stalled");

    // no command means zero payload
    a_idle_fields: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> (drive_valid || (drive_linear == '0 && drive_angular == '0)) &&
        (request_valid || request_code == '0) && (profile_valid || profile_id == '0))
        else $error("payload set without its valid flag");

    // an accepted drive is issued and leaves the block driving
    a_accept_drive: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && feedback_code == FB_ACCEPT |-> drive_valid && action_now == ACT_DRIVE)
        else $error("accepted drive not issued");

    // pause and resume match the resulting action
    a_pause_resume: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && pause_resume != PR_NONE |->
        (pause_resume == PR_PAUSE && action_now == ACT_XPAUSED) ||
        (pause_resume == PR_RESUME && action_now == ACT_XFORM))
        else $error("pause/resume inconsistent with action");

    // a request always carries a profile and a drive with zero linear velocity, and leaves the block transforming
    a_request: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && request_valid |-> profile_valid && drive_valid &&
        drive_linear == '0 && action_now == ACT_XFORM)
        else $error("transform request incomplete");

endmodule

bind robot_mode_supervisor_unit rms_checker u_rms_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .res_valid     (res.valid),
    .res_ready     (res.ready),
    .drive_valid   (res.drive_valid),
    .drive_linear  (res.drive_linear),
    .drive_angular (res.drive_angular),
    .request_valid (res.request_valid),
    .request_code  (res.request_code),
    .pause_resume  (res.pause_resume),
    .profile_valid (res.profile_valid),
    .profile_id    (res.profile_id),
    .feedback_code (res.feedback_code),
    .action_now    (res.action_now)
);
